// ----- src/dbr_pkg.sv -----
package dbr_pkg;

  localparam int unsigned EXP_TABLE_ENTRIES_DEF = 256;
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [63:0] LN2_Q32   = 64'd2977044472;
  localparam int          OUT_MAX   = 128000;

  localparam int TIME_W = 20;
  localparam int GAIN_W = 18;
  localparam int RATE_W = 16;
  localparam int RESP_W = 18;
  localparam int EXP_W  = 25;  // Q0.24, 1.0 included
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ONSET  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_B = 2'd3;

  localparam logic [TIME_W-1:0] ONSET_RST  = 20'd15360;
  localparam logic [GAIN_W-1:0] GAIN_RST   = 18'd256;
  localparam logic [RATE_W-1:0] RATE_A_RST = 16'd3277;
  localparam logic [RATE_W-1:0] RATE_B_RST = 16'd19661;

  // 2^(-i/entries) in Q0.24 from a Taylor series of exp(-z), evaluated at elaboration
  function automatic logic [EXP_W-1:0] exp_entry(input int unsigned i,
                                                 input int unsigned entries);
    logic [63:0] z;
    logic [63:0] sum;
    logic [63:0] term;
    z = (64'(i) * LN2_Q32 + 64'(entries / 2)) / 64'(entries);
    sum  = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int unsigned n = 1; n < 24; n++) begin
      term = ((term * z) >> 32) / 64'(n);
      if (n[0]) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    return EXP_W'((sum + 64'd128) >> 8);
  endfunction

endpackage

// ----- src/dbr_if.sv -----
interface dbr_in_if;
  import dbr_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] sample_time;
  logic              last_sample;
  modport source (output valid, sample_time, last_sample, input ready);
  modport sink   (input valid, sample_time, last_sample, output ready);
endinterface

interface dbr_out_if;
  import dbr_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [RESP_W-1:0] response_value;
  logic                     last_value;
  modport source (output valid, response_value, last_value, input ready);
  modport sink   (input valid, response_value, last_value, output ready);
endinterface

// ----- src/dbr_exp.sv -----
// exp(-rate*d) in Q0.24, four register stages, advances when en is high
module dbr_exp
  import dbr_pkg::*;
#(
  parameter int unsigned EXP_ENTRIES = EXP_TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              en,
  input  logic [TIME_W-1:0] d,
  input  logic [RATE_W-1:0] rate,
  output logic [EXP_W-1:0]  e
);

  localparam int IW  = $clog2(EXP_ENTRIES);
  localparam int IW1 = $clog2(EXP_ENTRIES + 1);
  localparam int PW  = 16 + IW;

  logic [EXP_W-1:0] tbl [0:EXP_ENTRIES];
  for (genvar g = 0; g <= EXP_ENTRIES; g++) begin : g_tbl
    assign tbl[g] = exp_entry(g, EXP_ENTRIES);
  end

  // stage 1: x = rate*d in Q12.16
  logic [27:0] x_r;
  logic [35:0] rd;
  assign rd = 36'(rate) * 36'(d);

  // stage 2: y = x*log2(e), split into integer and fraction
  logic [58:0] y;
  logic [15:0] f_r;
  logic [4:0]  n_r;
  logic        big_r;
  assign y = 59'(x_r) * 59'(LOG2E_Q30);

  // stage 3: table read
  logic [PW-1:0]    p;
  logic [IW-1:0]    idx;
  logic [IW1-1:0]   idx_lo, idx_hi;
  logic [EXP_W-1:0] lo_r, hi_r;
  logic [15:0]      w_r;
  logic [4:0]       n2_r;
  logic             big2_r;
  assign p      = PW'(32'(f_r) * 32'(EXP_ENTRIES));
  assign idx    = p[PW-1:16];
  assign idx_lo = IW1'(idx);
  assign idx_hi = IW1'(idx) + IW1'(1);

  // stage 4: interpolate and scale by 2^-n
  logic [EXP_W-1:0] delta, v;
  logic [40:0]      step;
  logic [EXP_W-1:0] e_r;
  assign delta = (lo_r >= hi_r) ? lo_r - hi_r : hi_r - lo_r;
  assign step  = 41'(delta) * 41'(w_r);
  assign v     = (lo_r >= hi_r) ? lo_r - step[40:16] : lo_r + step[40:16];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r    <= rd[35:8];
      f_r    <= y[45:30];
      n_r    <= y[50:46];
      big_r  <= (y[58:46] >= 13'd25);
      lo_r   <= tbl[idx_lo];
      hi_r   <= tbl[idx_hi];
      w_r    <= p[15:0];
      n2_r   <= n_r;
      big2_r <= big_r;
      e_r    <= big2_r ? '0 : (v >> n2_r);
    end
  end

  assign e = e_r;

endmodule

// ----- src/delayed_biexponential_response.sv -----
// Delayed Bateman response: for each sample time t, d = t - onset_time and the result is
// gain*(exp(-rate_a*d) - exp(-rate_b*d)) in signed Q16, saturated to +-128000, or zero
// before onset. exp(-x) is 2^-f from an interpolated table times 2^-n. Fully pipelined:
// one item per cycle while the output is not stalled, through seven register stages.
// The two exponential units run side by side. A full output stalls the whole pipe, so
// input ready follows the output side. Configuration must be written only while idle;
// the block itself does not enforce it.
module delayed_biexponential_response
  import dbr_pkg::*;
#(
  parameter int unsigned EXP_TABLE_ENTRIES = EXP_TABLE_ENTRIES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data,
  dbr_in_if.sink               in_ch,
  dbr_out_if.source            out_ch
);

  localparam int DEPTH = 7;

  // configuration registers
  logic [TIME_W-1:0]        onset_r;
  logic signed [GAIN_W-1:0] gain_r;
  logic [RATE_W-1:0]        rate_a_r, rate_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      onset_r  <= ONSET_RST;
      gain_r   <= GAIN_RST;
      rate_a_r <= RATE_A_RST;
      rate_b_r <= RATE_B_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ONSET:  onset_r  <= cfg_data;
        REG_GAIN:   gain_r   <= cfg_data[GAIN_W-1:0];
        REG_RATE_A: rate_a_r <= cfg_data[RATE_W-1:0];
        REG_RATE_B: rate_b_r <= cfg_data[RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance
  logic en;
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] last_r;
  logic [DEPTH-1:0] ge_r;
  assign en = !vld_r[DEPTH-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DEPTH-2:0], in_ch.valid};
    end
  end

  // stage 1: elapsed time past onset
  logic [TIME_W-1:0] d_r;
  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= in_ch.sample_time - onset_r;
      ge_r   <= {ge_r[DEPTH-2:0], in_ch.sample_time >= onset_r};
      last_r <= {last_r[DEPTH-2:0], in_ch.last_sample};
    end
  end

  // stages 2..5: the two decays
  logic [EXP_W-1:0] ea, eb;
  dbr_exp #(.EXP_ENTRIES(EXP_TABLE_ENTRIES)) u_exp_a (
    .clk(clk), .en(en), .d(d_r), .rate(rate_a_r), .e(ea)
  );
  dbr_exp #(.EXP_ENTRIES(EXP_TABLE_ENTRIES)) u_exp_b (
    .clk(clk), .en(en), .d(d_r), .rate(rate_b_r), .e(eb)
  );

  // stage 6: gain times difference, Q32
  logic signed [EXP_W:0] diff;
  logic signed [43:0]    prod_r;
  assign diff = $signed({1'b0, ea}) - $signed({1'b0, eb});

  // stage 7: round half away from zero, saturate, zero before onset
  logic [43:0] mag;
  logic [28:0] q;
  logic [RESP_W-1:0] qs;
  logic signed [RESP_W-1:0] resp_r;
  assign mag = prod_r[43] ? 44'(-prod_r) : 44'(prod_r);
  assign q   = 29'((mag + 44'd32768) >> 16);
  assign qs  = (q > 29'(OUT_MAX)) ? RESP_W'(OUT_MAX) : q[RESP_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= 44'(gain_r) * 44'(diff);
      if (!ge_r[DEPTH-2]) begin
        resp_r <= '0;
      end else begin
        resp_r <= prod_r[43] ? -$signed(qs) : $signed(qs);
      end
    end
  end

  assign out_ch.valid          = vld_r[DEPTH-1];
  assign out_ch.response_value = resp_r;
  assign out_ch.last_value     = last_r[DEPTH-1];

endmodule

// ----- src/dbr_checker.sv -----
module dbr_checker
  import dbr_pkg::*;
(
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic signed [RESP_W-1:0] out_value,
  input logic                     out_last
);

  // a waiting item stays until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_last))
    else $error("output item changed while stalled");

  // pipe empties on reset
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // input is taken whenever the output side can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output side");

  // saturation bounds
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value <= 18'sd128000) && (out_value >= -18'sd128000))
    else $error("result outside saturation range");

endmodule

bind delayed_biexponential_response dbr_checker u_dbr_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_value(out_ch.response_value),
  .out_last(out_ch.last_value)
);

// ----- dv/delayed_biexponential_response_tb.sv -----
`timescale 1ns / 1ps

module delayed_biexponential_response_tb;
  import dbr_pkg::*;

  localparam int N_ENTRIES = 256;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0] cfg_data = '0;

  dbr_in_if in_ch ();
  dbr_out_if out_ch ();

  delayed_biexponential_response dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always #4 clk = ~clk;

  typedef struct packed {
    logic signed [RESP_W-1:0] response;
    logic last;
  } resp_t;

  // predictor copy of the registers and the pow2 table
  logic [TIME_W-1:0] onset_q = ONSET_RST;
  logic signed [GAIN_W-1:0] gain_q = GAIN_RST;
  logic [RATE_W-1:0] rate_a_q = RATE_A_RST;
  logic [RATE_W-1:0] rate_b_q = RATE_B_RST;
  logic [63:0] pow2_lut [0:N_ENTRIES];

  resp_t pending_resp [$];
  int mismatches = 0;
  int items_sent = 0;
  int items_checked = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit timed_out = 0;

  // Taylor series of exp(-z), z Q0.32, result Q0.24
  function automatic logic [63:0] taylor_exp_q24(logic [63:0] z);
    logic [63:0] sum;
    logic [63:0] term;
    sum = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int k = 1; k < 24; k++) begin
      term = ((term * z) >> 32) / 64'(k);
      if (k % 2 == 1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    return (sum + 64'd128) >> 8;
  endfunction

  function automatic logic [63:0] decay_q24(logic [RATE_W-1:0] rate, logic [TIME_W-1:0] d);
    logic [63:0] x16;
    logic [127:0] y;
    logic [63:0] n, f, p, idx, w, lo, hi, v;
    x16 = (64'(rate) * 64'(d)) >> 8;
    y = 128'(x16) * 128'(LOG2E_Q30);
    n = 64'(y >> 46);
    f = 64'(y >> 30) & 64'hFFFF;
    p = f * N_ENTRIES;
    idx = p >> 16;
    w = p & 64'hFFFF;
    if (idx >= N_ENTRIES) begin
      idx = N_ENTRIES - 1;
      w = 64'hFFFF;
    end
    lo = pow2_lut[idx];
    hi = pow2_lut[idx + 1];
    if (lo >= hi) v = lo - (((lo - hi) * w) >> 16);
    else v = lo + (((hi - lo) * w) >> 16);
    if (n >= 25) return 64'd0;
    return v >> n;
  endfunction

  function automatic resp_t predict_response(logic [TIME_W-1:0] t, logic last);
    resp_t r;
    longint diff, prod, q;
    longint unsigned mag;
    r.last = last;
    r.response = '0;
    if (t >= onset_q) begin
      diff = longint'(decay_q24(rate_a_q, t - onset_q)) -
             longint'(decay_q24(rate_b_q, t - onset_q));
      prod = longint'(gain_q) * diff;
      mag = (prod < 0) ? -prod : prod;
      q = (mag + (64'd1 << 15)) >> 16;
      if (q > OUT_MAX) q = OUT_MAX;
      r.response = RESP_W'((prod < 0) ? -q : q);
    end
    return r;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ONSET:  onset_q = val;
      REG_GAIN:   gain_q = val[GAIN_W-1:0];
      REG_RATE_A: rate_a_q = val[RATE_W-1:0];
      REG_RATE_B: rate_b_q = val[RATE_W-1:0];
      default: ;
    endcase
  endtask

  // send one item, with optional expected value typed in; valid stays high afterwards
  // so items can follow back to back
  task automatic send_sample(logic [TIME_W-1:0] t, logic last, bit has_exp = 0,
                             logic signed [RESP_W-1:0] exp_val = '0);
    resp_t r;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    r = predict_response(t, last);
    if (has_exp && r.response !== exp_val)
      $display("table row t=%0d: predictor %0d vs typed %0d", t, r.response, exp_val);
    if (has_exp) r.response = exp_val;
    pending_resp.push_back(r);
    in_ch.valid <= 1'b1;
    in_ch.sample_time <= t;
    in_ch.last_sample <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_resp.size() != 0 && !timed_out) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver stall
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    resp_t expv;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_resp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", out_ch.response_value);
      end else begin
        expv = pending_resp.pop_front();
        items_checked++;
        if (out_ch.response_value !== expv.response || out_ch.last_value !== expv.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d/%0b got %0d/%0b", expv.response, expv.last,
                     out_ch.response_value, out_ch.last_value);
        end
      end
    end
  end

  // watchdog on accepted traffic
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n ||
        (pending_resp.size() == 0 && !in_ch.valid))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      timed_out = 1;
      $display("watchdog expired");
      $display("*** FAILED ***");
      $finish;
    end
  end

  typedef struct {
    logic [TIME_W-1:0] t;
    logic last;
    bit has_exp;
    logic signed [RESP_W-1:0] exp_val;
  } row_t;

  row_t dir_rows [] = '{
    '{20'd0, 1'b0, 1'b1, 18'sd0},            // before onset
    '{20'd15359, 1'b1, 1'b1, 18'sd0},        // just before onset
    '{20'd15360, 1'b0, 1'b1, 18'sd0},        // at onset
    '{20'd15361, 1'b1, 1'b0, 18'sd0},
    '{20'd16000, 1'b0, 1'b0, 18'sd0},
    '{20'd20000, 1'b1, 1'b0, 18'sd0},
    '{20'hAAAAA, 1'b0, 1'b0, 18'sd0},
    '{20'h55555, 1'b1, 1'b0, 18'sd0},
    '{20'hFFFFF, 1'b1, 1'b0, 18'sd0}         // time at maximum
  };

  initial begin
    logic [TIME_W-1:0] t;
    int base;
    in_ch.valid = 1'b0;
    in_ch.sample_time = '0;
    in_ch.last_sample = 1'b0;
    for (int i = 0; i <= N_ENTRIES; i++)
      pow2_lut[i] = taylor_exp_q24((64'(i) * LN2_Q32 + N_ENTRIES / 2) / N_ENTRIES);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table at reset settings
    foreach (dir_rows[i])
      send_sample(dir_rows[i].t, dir_rows[i].last, dir_rows[i].has_exp, dir_rows[i].exp_val);
    wait_idle();

    // extreme settings: zero onset, max gain both signs, rate extremes
    write_reg(REG_ONSET, 20'd0);
    write_reg(REG_GAIN, 20'(18'sh1FFFF));
    write_reg(REG_RATE_A, 20'd0);
    write_reg(REG_RATE_B, 20'hFFFF);
    send_sample(20'd0, 1'b0, 1'b1, 18'sd0);   // d = 0 gives zero
    send_sample(20'd1, 1'b1);
    send_sample(20'd256, 1'b0);
    send_sample(20'hFFFFF, 1'b1);
    wait_idle();
    write_reg(REG_GAIN, 20'(18'sh20000));     // most negative 18-bit value
    send_sample(20'd512, 1'b0);
    send_sample(20'd3000, 1'b1);
    wait_idle();
    write_reg(REG_ONSET, 20'hFFFFF);
    write_reg(REG_RATE_A, 20'hFFFF);
    write_reg(REG_RATE_B, 20'd0);
    send_sample(20'hFFFFF, 1'b1, 1'b1, 18'sd0);
    send_sample(20'hFFFFE, 1'b0, 1'b1, 18'sd0);
    wait_idle();

    // random phases with different idling and settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      write_reg(REG_ONSET, (ph == 7) ? 20'd0 : 20'($urandom_range(0, 40000)));
      write_reg(REG_GAIN, 20'($urandom_range(0, 18'h3FFFF)));
      write_reg(REG_RATE_A, 20'($urandom_range(0, 16'hFFFF) >> $urandom_range(0, 12)));
      write_reg(REG_RATE_B, 20'($urandom_range(0, 16'hFFFF) >> $urandom_range(0, 12)));
      // random times around and after onset, with occasional noise
      base = onset_q;
      for (int k = 0; k < 100; k++) begin
        if ($urandom_range(9) < 8)
          t = 20'(base + $urandom_range(0, 4000) - 200);
        else
          t = 20'($urandom);
        send_sample(t, (k % 20 == 19) ? 1'b1 : $urandom_range(1) == 0 && k % 7 == 0);
        if ($urandom_range(99) < 20) send_idle_pct = (send_idle_pct == 0) ? 0 : send_idle_pct;
      end
      wait_idle();
    end

    $display("sent %0d samples, checked %0d results over reset, extreme and random settings",
             items_sent, items_checked);
    $display("idling phases: none, sender 54%%, receiver 54%%, both 35%%");
    if (mismatches == 0 && pending_resp.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
